>>> design/mdars_pkg.sv
// Shared types and constants for the multi-device ack/retry sequencer.
`default_nettype none
package mdars_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int IDX_W = $clog2(MAX_DEVICES);
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_ACK   = 2'd3;

  localparam logic [1:0] REG_RETRY   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAX_ATT = 2'd2;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_RTT  = 3'd1;
  localparam logic [2:0] KIND_FIN  = 3'd2;
  localparam logic [2:0] KIND_FAIL = 3'd3;
  localparam logic [2:0] KIND_OK   = 3'd4;

  // x/1000 = ((x >> 3) * DIV_MUL) >> DIV_SHIFT for any 32-bit x
  localparam int          DIV_SHIFT = 36;
  localparam logic [29:0] DIV_MUL   = 30'd549755814;

  typedef enum logic [2:0] {
    ST_PEND_RTT = 3'd0,
    ST_WAIT_RTT = 3'd1,
    ST_PEND_FIN = 3'd2,
    ST_WAIT_FIN = 3'd3,
    ST_SUCCESS  = 3'd4,
    ST_FAILED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_TICK = 2'd1,
    OP_ACK  = 2'd2,
    OP_EMIT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic        stall;
    logic [31:0] now_ms;
    logic [31:0] now_us;
    logic [7:0]  ack_id;
    logic [31:0] ack_orig;
    logic [31:0] ack_rxp;
    logic [15:0] retry;
    logic [15:0] timeout;
    logic [3:0]  max_att;
    logic [7:0]  ld_id;
    logic [31:0] ld_delay;
    logic [31:0] ld_play;
  } cell_ctrl_t;

  typedef struct packed {
    logic visit;
    logic found;
  } chain_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [31:0] delay;
    logic [31:0] play;
    logic [31:0] rtt;
    logic [31:0] rxp;
  } cell_res_t;

endpackage
`default_nettype wire

>>> design/multi_device_ack_retry_sequencer_core.sv
// Top level: command sequencer driving a chain of device entry cells.
// Usage: items enter on in_* (valid/ready), results leave on out_* (valid/ready);
// cfg_we/cfg_index/cfg_wdata set retry interval, ack timeout and attempt limit
// while the block is idle. in_ready is high only between items.
// Start: its single result is loaded in S_REPORT. Add: S_ADD1, S_ADD2, then
// S_REPORT. Ack: a token walks the MAX_DEVICES cells, one per cycle, then the
// result is loaded in S_REPORT, after the latency math in S_FIN1, S_FIN2 and
// S_FIN3 when a device completes. Tick: one walk of the cells to update them,
// then a second walk that hands out one result per device that sends or fails,
// each beat loaded as the token reaches its cell; a tick with nothing to hand
// out reports in S_REPORT. The cell walks set the rate: one item at a time,
// in_ready returns when the walk is over.
// Every input gives at least one result; the last carries out_last_of_run.
// A stalled receiver freezes the second walk in place; the result register
// holds its beat until taken. Reset empties the table and loads the default
// register values; no clearing pass is needed.
`default_nettype none
module multi_device_ack_retry_sequencer_core import mdars_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_device_id,
  input  wire logic [7:0]  in_delay_min,
  input  wire logic [5:0]  in_delay_sec,
  input  wire logic [15:0] in_play_sec,
  input  wire logic [31:0] in_time_ms,
  input  wire logic [31:0] in_time_us,
  input  wire logic [31:0] in_button_press_us,
  input  wire logic [31:0] in_ack_orig_tx_us,
  input  wire logic [31:0] in_ack_rx_proc_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_result_kind,
  output logic [7:0]       out_device_id,
  output logic [31:0]      out_tx_stamp_us,
  output logic [31:0]      out_delay_ms,
  output logic [31:0]      out_play_ms,
  output logic [31:0]      out_rtt_us,
  output logic [31:0]      out_rx_proc_us,
  output logic [31:0]      out_delay_end_ms,
  output logic [31:0]      out_play_end_ms,
  output logic             out_all_done,
  output logic             out_last_of_run,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ADD1   = 9'b000000010,
    S_ADD2   = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_EMIT   = 9'b000010000,
    S_FIN1   = 9'b000100000,
    S_FIN2   = 9'b001000000,
    S_FIN3   = 9'b010000000,
    S_REPORT = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [7:0]  id_r;
  logic [7:0]  dmin_r;
  logic [5:0]  dsec_r;
  logic [15:0] psec_r;
  logic [31:0] now_ms_r, now_us_r, orig_r, rxp_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] button_r, button_nxt;
  logic [15:0] retry_r, timeout_r;
  logic [3:0]  max_att_r;
  logic        launch_r, launch_nxt;
  logic        fin_hit_r, fin_hit_nxt;
  logic        emitted_r, emitted_nxt;
  logic [13:0] sec_tot_r;
  logic [7:0]  fin_id_r;
  logic [31:0] fin_rtt_r, fin_rxp_r, fin_delay_r, fin_play_r;
  logic [31:0] start_us_r;
  logic [58:0] prod_r;
  logic [31:0] dend_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [2:0]  o_kind_r, o_kind_nxt;
  logic [7:0]  o_id_r, o_id_nxt;
  logic [31:0] o_tx_r, o_tx_nxt, o_dly_r, o_dly_nxt, o_ply_r, o_ply_nxt;
  logic [31:0] o_rtt_r, o_rtt_nxt, o_rxp_r, o_rxp_nxt;
  logic [31:0] o_dend_r, o_dend_nxt, o_pend_r, o_pend_nxt;
  logic        o_done_r, o_done_nxt, o_last_r, o_last_nxt;

  logic        accept, stall, all_done, last_emit;
  logic [31:0] lat;
  cell_ctrl_t  ctrl;
  chain_t      chain_in  [MAX_DEVICES];
  chain_t      chain_out [MAX_DEVICES];
  cell_res_t   res_v     [MAX_DEVICES];
  cell_res_t   res_any;
  logic [MAX_DEVICES-1:0] active, load_v, emit_v, done_v, vis;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign stall    = (state_r == S_EMIT) && out_valid_r && !out_ready;

  always_comb begin
    ctrl          = '0;
    ctrl.op       = (state_r == S_SCAN) ? ((cmd_r == CMD_TICK) ? OP_TICK : OP_ACK) :
                    (state_r == S_EMIT) ? OP_EMIT : OP_IDLE;
    ctrl.stall    = stall;
    ctrl.now_ms   = now_ms_r;
    ctrl.now_us   = now_us_r;
    ctrl.ack_id   = id_r;
    ctrl.ack_orig = orig_r;
    ctrl.ack_rxp  = rxp_r;
    ctrl.retry    = retry_r;
    ctrl.timeout  = timeout_r;
    ctrl.max_att  = max_att_r;
    ctrl.ld_id    = id_r;
    ctrl.ld_delay = 32'(sec_tot_r) * 32'd1000;
    ctrl.ld_play  = 32'(psec_r) * 32'd1000;
  end

  for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in[g] = '{visit: launch_r, found: 1'b0};
    end else begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    assign active[g] = (CNT_W'(g) < count_r);
    assign load_v[g] = (state_r == S_ADD2) && (count_r == CNT_W'(g));
    assign vis[g]    = chain_in[g].visit;
    mdars_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .active    (active[g]),
      .load      (load_v[g]),
      .chain_in  (chain_in[g]),
      .chain_out (chain_out[g]),
      .res       (res_v[g]),
      .emit      (emit_v[g]),
      .done      (done_v[g])
    );
  end

  always_comb begin
    res_any = '0;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      res_any = cell_res_t'(res_any | res_v[i]);
    end
  end

  assign all_done  = &(done_v | ~active);
  // no emitting cell beyond the one holding the token
  assign last_emit = ~|(emit_v & ~((vis << 1) - MAX_DEVICES'(1)));
  assign lat = (fin_rtt_r > fin_rxp_r) ? ((fin_rtt_r - fin_rxp_r) >> 1) : 32'd0;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    button_nxt  = button_r;
    launch_nxt  = stall ? launch_r : 1'b0;
    fin_hit_nxt = fin_hit_r;
    emitted_nxt = emitted_r;
    out_load    = 1'b0;
    o_kind_nxt  = KIND_NONE;
    o_id_nxt    = '0;
    o_tx_nxt    = '0;
    o_dly_nxt   = '0;
    o_ply_nxt   = '0;
    o_rtt_nxt   = '0;
    o_rxp_nxt   = '0;
    o_dend_nxt  = '0;
    o_pend_nxt  = '0;
    o_done_nxt  = all_done;
    o_last_nxt  = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fin_hit_nxt = 1'b0;
          emitted_nxt = 1'b0;
          case (in_command)
            CMD_START: begin
              count_nxt  = '0;
              button_nxt = in_button_press_us;
              state_nxt  = S_REPORT;
            end
            CMD_ADD: state_nxt = S_ADD1;
            default: begin
              launch_nxt = 1'b1;
              state_nxt  = S_SCAN;
            end
          endcase
        end
      end
      S_ADD1: state_nxt = S_ADD2;
      S_ADD2: begin
        if (count_r < CNT_W'(MAX_DEVICES)) count_nxt = count_r + CNT_W'(1);
        state_nxt = S_REPORT;
      end
      S_SCAN: begin
        if (res_any.valid) fin_hit_nxt = 1'b1;
        if (chain_out[MAX_DEVICES-1].visit) begin
          if (cmd_r == CMD_TICK) begin
            launch_nxt = 1'b1;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = (fin_hit_r || res_any.valid) ? S_FIN1 : S_REPORT;
          end
        end
      end
      S_EMIT: begin
        if (res_any.valid && !stall) begin
          out_load    = 1'b1;
          emitted_nxt = 1'b1;
          o_kind_nxt  = res_any.kind;
          o_id_nxt    = res_any.id;
          o_tx_nxt    = (res_any.kind == KIND_FAIL) ? 32'd0 : now_us_r;
          o_dly_nxt   = res_any.delay;
          o_ply_nxt   = res_any.play;
          o_rtt_nxt   = res_any.rtt;
          o_rxp_nxt   = res_any.rxp;
          o_last_nxt  = last_emit;
        end
        if (chain_out[MAX_DEVICES-1].visit) begin
          state_nxt = emitted_r ? S_IDLE : S_REPORT;
        end
      end
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_FIN3;
      S_FIN3: state_nxt = S_REPORT;
      S_REPORT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (fin_hit_r) begin
            o_kind_nxt = KIND_OK;
            o_id_nxt   = fin_id_r;
            o_dend_nxt = dend_r;
            o_pend_nxt = dend_r + fin_play_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      button_r    <= '0;
      launch_r    <= 1'b0;
      fin_hit_r   <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      retry_r     <= 16'd100;
      timeout_r   <= 16'd100;
      max_att_r   <= 4'd3;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      button_r    <= button_nxt;
      launch_r    <= launch_nxt;
      fin_hit_r   <= fin_hit_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RETRY:   retry_r   <= cfg_wdata;
          REG_TIMEOUT: timeout_r <= cfg_wdata;
          REG_MAX_ATT: max_att_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      id_r     <= in_device_id;
      dmin_r   <= in_delay_min;
      dsec_r   <= in_delay_sec;
      psec_r   <= in_play_sec;
      now_ms_r <= in_time_ms;
      now_us_r <= in_time_us;
      orig_r   <= in_ack_orig_tx_us;
      rxp_r    <= in_ack_rx_proc_us;
    end
    if (state_r == S_ADD1) sec_tot_r <= 14'(dmin_r) * 14'd60 + 14'(dsec_r);
    if (state_r == S_SCAN && res_any.valid) begin
      fin_id_r    <= res_any.id;
      fin_rtt_r   <= res_any.rtt;
      fin_rxp_r   <= res_any.rxp;
      fin_delay_r <= res_any.delay;
      fin_play_r  <= res_any.play;
    end
    if (state_r == S_FIN1) start_us_r <= button_r + lat;
    if (state_r == S_FIN2) prod_r <= start_us_r[31:3] * DIV_MUL;
    if (state_r == S_FIN3) dend_r <= {9'd0, prod_r[58:DIV_SHIFT]} + fin_delay_r;
    if (out_load) begin
      o_kind_r <= o_kind_nxt;
      o_id_r   <= o_id_nxt;
      o_tx_r   <= o_tx_nxt;
      o_dly_r  <= o_dly_nxt;
      o_ply_r  <= o_ply_nxt;
      o_rtt_r  <= o_rtt_nxt;
      o_rxp_r  <= o_rxp_nxt;
      o_dend_r <= o_dend_nxt;
      o_pend_r <= o_pend_nxt;
      o_done_r <= o_done_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = o_kind_r;
  assign out_device_id    = o_id_r;
  assign out_tx_stamp_us  = o_tx_r;
  assign out_delay_ms     = o_dly_r;
  assign out_play_ms      = o_ply_r;
  assign out_rtt_us       = o_rtt_r;
  assign out_rx_proc_us   = o_rxp_r;
  assign out_delay_end_ms = o_dend_r;
  assign out_play_end_ms  = o_pend_r;
  assign out_all_done     = o_done_r;
  assign out_last_of_run  = o_last_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vis))
    else $error("more than one cell visited at once");
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (vis == '0))
    else $error("token still in chain while idle");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DEVICES))
    else $error("entry count beyond table size");
  a_scan_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !stall)
    else $error("update walk stalled");

endmodule
`default_nettype wire

>>> design/mdars_cell.sv
// One device entry: holds its handshake state and acts when the token visits.
`default_nettype none
module mdars_cell import mdars_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       active,
  input  wire logic       load,
  input  wire chain_t     chain_in,
  output chain_t          chain_out,
  output cell_res_t       res,
  output logic            emit,
  output logic            done
);

  logic [7:0]  id_r, id_nxt;
  status_t     status_r, status_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [31:0] last_send_r, last_send_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [31:0] last_tx_r, last_tx_nxt;
  logic [31:0] rtt_r, rtt_nxt;
  logic [31:0] rxp_r, rxp_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [31:0] play_r, play_nxt;
  logic        emit_r, emit_nxt;
  logic [2:0]  emit_kind_r, emit_kind_nxt;
  chain_t      chain_r, chain_nxt;

  logic        is_done, due, timed_out, matched;
  logic [3:0]  att2;
  status_t     st2;

  assign is_done = (status_r == ST_SUCCESS) || (status_r == ST_FAILED);
  assign due = (att_r == 4'd0) ||
               ((ctrl.now_ms - last_send_r) >= {16'd0, ctrl.retry});
  assign timed_out = ((status_r == ST_WAIT_RTT) || (status_r == ST_WAIT_FIN)) &&
                     (ctrl.now_ms >= deadline_r);
  assign att2 = (timed_out && att_r != 4'hF) ? att_r + 4'd1 : att_r;
  assign st2 = !timed_out ? status_r :
               (status_r == ST_WAIT_RTT) ? ST_PEND_RTT : ST_PEND_FIN;
  assign matched = (id_r == ctrl.ack_id) && (last_tx_r == ctrl.ack_orig) &&
                   ((status_r == ST_WAIT_RTT) || (status_r == ST_WAIT_FIN));

  always_comb begin
    id_nxt        = id_r;
    status_nxt    = status_r;
    att_nxt       = att_r;
    last_send_nxt = last_send_r;
    deadline_nxt  = deadline_r;
    last_tx_nxt   = last_tx_r;
    rtt_nxt       = rtt_r;
    rxp_nxt       = rxp_r;
    delay_nxt     = delay_r;
    play_nxt      = play_r;
    emit_nxt      = emit_r;
    emit_kind_nxt = emit_kind_r;
    chain_nxt     = chain_in;
    res           = '0;
    if (load) begin
      id_nxt        = ctrl.ld_id;
      status_nxt    = ST_PEND_RTT;
      att_nxt       = 4'd0;
      last_send_nxt = '0;
      deadline_nxt  = '0;
      last_tx_nxt   = '0;
      rtt_nxt       = '0;
      rxp_nxt       = '0;
      delay_nxt     = ctrl.ld_delay;
      play_nxt      = ctrl.ld_play;
      emit_nxt      = 1'b0;
    end else if (chain_in.visit && active) begin
      case (ctrl.op)
        OP_TICK: begin
          emit_nxt = 1'b0;
          if (!is_done) begin
            att_nxt    = att2;
            status_nxt = st2;
            if (att2 >= ctrl.max_att) begin
              status_nxt    = ST_FAILED;
              emit_nxt      = 1'b1;
              emit_kind_nxt = KIND_FAIL;
            end else if (due && (st2 == ST_PEND_RTT || st2 == ST_PEND_FIN)) begin
              last_send_nxt = ctrl.now_ms;
              deadline_nxt  = ctrl.now_ms + {16'd0, ctrl.timeout};
              last_tx_nxt   = ctrl.now_us;
              status_nxt    = (st2 == ST_PEND_RTT) ? ST_WAIT_RTT : ST_WAIT_FIN;
              emit_nxt      = 1'b1;
              emit_kind_nxt = (st2 == ST_PEND_RTT) ? KIND_RTT : KIND_FIN;
            end
          end
        end
        OP_ACK: begin
          if (!chain_in.found && matched) begin
            chain_nxt.found = 1'b1;
            if (status_r == ST_WAIT_RTT) begin
              rtt_nxt    = ctrl.now_us - ctrl.ack_orig;
              rxp_nxt    = ctrl.ack_rxp;
              status_nxt = ST_PEND_FIN;
              att_nxt    = 4'd0;
            end else begin
              status_nxt = ST_SUCCESS;
              res.valid  = 1'b1;
              res.kind   = KIND_OK;
              res.id     = id_r;
              res.delay  = delay_r;
              res.play   = play_r;
              res.rtt    = rtt_r;
              res.rxp    = rxp_r;
            end
          end
        end
        OP_EMIT: begin
          if (emit_r) begin
            res.valid = 1'b1;
            res.kind  = emit_kind_r;
            res.id    = id_r;
            if (emit_kind_r != KIND_FAIL) begin
              res.delay = delay_r;
              res.play  = play_r;
              res.rtt   = rtt_r;
              res.rxp   = rxp_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.stall) begin
      id_r        <= id_nxt;
      status_r    <= status_nxt;
      att_r       <= att_nxt;
      last_send_r <= last_send_nxt;
      deadline_r  <= deadline_nxt;
      last_tx_r   <= last_tx_nxt;
      rtt_r       <= rtt_nxt;
      rxp_r       <= rxp_nxt;
      delay_r     <= delay_nxt;
      play_r      <= play_nxt;
      emit_kind_r <= emit_kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r  <= 1'b0;
      chain_r <= '0;
    end else if (!ctrl.stall) begin
      emit_r  <= emit_nxt;
      chain_r <= chain_nxt;
    end
  end

  assign chain_out = chain_r;
  assign emit      = emit_r & active;
  assign done      = is_done;

endmodule
`default_nettype wire
